### hw/rtl/rsa_phase_stim_gate_defines.svh
// Assertion macros shared by the checker of the phase stimulation gate.
// No dependencies; included by the files that carry assertions.
`ifndef RSA_PHASE_STIM_GATE_DEFINES_SVH
`define RSA_PHASE_STIM_GATE_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define RPSG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define RPSG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/rpsg_pkg.sv
// Shared types and constants of the phase stimulation gate.
// No dependencies; imported by the gate, its mean divider and its checker.
package rpsg_pkg;

    localparam int FUNC_W    = 2;
    localparam int RR_W      = 12;
    localparam int TIME_W    = 32;
    localparam int FREQ_W    = 10;
    localparam int CUR_W     = 13;
    localparam int TH_W      = 12;
    localparam int MAXT_W    = 16;
    localparam int CNT_W     = 16;
    localparam int DIFF_W    = 13;
    localparam int MEAN_W    = 13;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [FREQ_W-1:0] FREQ_MIN = FREQ_W'(1);
    localparam logic [FREQ_W-1:0] FREQ_MAX = FREQ_W'(1000);
    localparam logic [FREQ_W-1:0] FREQ_RST = FREQ_W'(25);
    localparam logic [CUR_W-1:0]  CUR_MIN  = CUR_W'(100);
    localparam logic [CUR_W-1:0]  CUR_MAX  = CUR_W'(5000);
    localparam logic [CUR_W-1:0]  CUR_RST  = CUR_W'(500);
    localparam int                TH_RST   = 5;
    localparam logic [MAXT_W-1:0] MAXT_RST = MAXT_W'(5000);

    typedef enum logic [FUNC_W-1:0] {
        FN_BEAT      = 2'd0,
        FN_TICK      = 2'd1,
        FN_FORCE_OFF = 2'd2,
        FN_SAFETY    = 2'd3
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FREQ    = 2'd0,
        CFG_CURRENT = 2'd1,
        CFG_SLOPE   = 2'd2,
        CFG_MAXT    = 2'd3
    } t_cfg_idx;

endpackage

### hw/rtl/rpsg_mean.sv
// Window mean of the RR difference sum, truncated toward zero.
// Divides by the window length through a reciprocal multiply; uses rpsg_pkg.
module rpsg_mean
    import rpsg_pkg::*;
#(
    parameter int WINDOW_LEN = 8,
    parameter int SUM_W      = DIFF_W + $clog2(WINDOW_LEN)
) (
    input  logic signed [SUM_W-1:0]  i_sum,
    output logic signed [MEAN_W-1:0] o_mean
);

    localparam int AW = SUM_W - 1;
    localparam int LG = $clog2(WINDOW_LEN);
    localparam int K  = AW + LG;
    localparam int MW = AW + 1;
    localparam int PW = AW + MW;
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << K) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

    logic              w_neg;
    logic [SUM_W-1:0]  w_mag;
    logic [AW-1:0]     w_abs;
    logic [PW-1:0]     w_prod;
    logic [MEAN_W-1:0] w_quo;

    assign w_neg  = i_sum[SUM_W-1];
    assign w_mag  = w_neg ? (~i_sum + SUM_W'(1)) : i_sum;
    assign w_abs  = w_mag[AW-1:0];
    assign w_prod = PW'(w_abs) * PW'(RECIP);
    assign w_quo  = MEAN_W'(w_prod[PW-1:K]);
    assign o_mean = w_neg ? signed'(~w_quo + MEAN_W'(1)) : signed'(w_quo);

endmodule

### hw/rtl/rsa_phase_stim_gate.sv
// Phase stimulation gate: RR slope window, hysteresis band and stimulation phase control.
// Uses rpsg_pkg and rpsg_mean.
// A request is registered in the input stage, then in the state stage, then in the output stage,
// where its result is valid. Throughput: one request per cycle while the output is not stalled;
// ring update and band compare close in the state stage, the mean divide sits in the output stage.
// Reset (synchronous, active low): clears window, counters, phase and valids, loads defaults.
module rsa_phase_stim_gate
    import rpsg_pkg::*;
#(
    parameter int WINDOW_LEN = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [FUNC_W-1:0]        i_func,
    input  logic [RR_W-1:0]          i_rr_ms,
    input  logic [TIME_W-1:0]        i_now_ms,
    input  logic                     i_grant,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [1:0]               o_phase,
    output logic                     o_gate_on,
    output logic                     o_enable_event,
    output logic                     o_disable_event,
    output logic [FREQ_W-1:0]        o_cmd_freq_hz,
    output logic [CUR_W-1:0]         o_cmd_current_ua,
    output logic [CNT_W-1:0]         o_stim_total,
    output logic [TIME_W-1:0]        o_last_duration_ms,
    output logic                     o_safety_ok,
    output logic signed [MEAN_W-1:0] o_slope_avg,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_wdata
);

    localparam int PW    = $clog2(WINDOW_LEN);
    localparam int SUM_W = DIFF_W + PW;
    localparam logic [SUM_W-1:0] LIM_RST = SUM_W'((TH_RST + 1) * WINDOW_LEN);
    localparam logic [PW-1:0]    POS_LAST = PW'(WINDOW_LEN - 1);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_STIM = 2'd1,
        PH_COOL = 2'd2
    } t_phase;

    // configuration
    logic [FREQ_W-1:0] r_freq;
    logic [CUR_W-1:0]  r_cur;
    logic [SUM_W-1:0]  r_lim;
    logic [MAXT_W-1:0] r_maxt;
    logic [TH_W:0]     w_th_inc;
    logic [SUM_W-1:0]  w_lim_new;

    // pipeline control
    logic w_adv0;
    logic w_adv1;
    logic w_adv2;
    logic w_step;

    // input stage
    logic              r_s0_v;
    t_func             r_s0_func;
    logic [RR_W-1:0]   r_s0_rr;
    logic [TIME_W-1:0] r_s0_now;
    logic              r_s0_grant;

    // block state
    logic signed [DIFF_W-1:0] r_win [WINDOW_LEN];
    logic [PW-1:0]            r_wpos;
    logic signed [SUM_W-1:0]  r_sum;
    logic [RR_W-1:0]          r_last_rr;
    t_phase                   r_phase;
    logic [TIME_W-1:0]        r_start;
    logic [CNT_W-1:0]         r_cnt;
    logic [TIME_W-1:0]        r_dur;
    logic                     r_ok;

    logic [PW-1:0]            n_wpos;
    logic signed [SUM_W-1:0]  n_sum;
    logic [RR_W-1:0]          n_last_rr;
    t_phase                   n_phase;
    logic [TIME_W-1:0]        n_start;
    logic [CNT_W-1:0]         n_cnt;
    logic [TIME_W-1:0]        n_dur;
    logic                     n_ok;
    logic                     n_en;
    logic                     n_dis;

    logic signed [DIFF_W-1:0] w_diff;
    logic signed [DIFF_W-1:0] w_old;
    logic signed [SUM_W-1:0]  w_sum_beat;
    logic signed [SUM_W:0]    w_sum_x;
    logic signed [SUM_W:0]    w_lim_x;
    logic                     w_above;
    logic                     w_below;
    logic [TIME_W-1:0]        w_elapsed;
    logic                     w_timeout;

    // state stage snapshot
    logic                    r_s1_v;
    t_phase                  r_s1_phase;
    logic                    r_s1_en;
    logic                    r_s1_dis;
    logic [FREQ_W-1:0]       r_s1_freq;
    logic [CUR_W-1:0]        r_s1_cur;
    logic [CNT_W-1:0]        r_s1_cnt;
    logic [TIME_W-1:0]       r_s1_dur;
    logic                    r_s1_ok;
    logic signed [SUM_W-1:0] r_s1_sum;

    // output stage
    logic                     r_out_v;
    t_phase                   r_out_phase;
    logic                     r_out_en;
    logic                     r_out_dis;
    logic [FREQ_W-1:0]        r_out_freq;
    logic [CUR_W-1:0]         r_out_cur;
    logic [CNT_W-1:0]         r_out_cnt;
    logic [TIME_W-1:0]        r_out_dur;
    logic                     r_out_ok;
    logic signed [MEAN_W-1:0] r_out_mean;
    logic signed [MEAN_W-1:0] w_mean;

    assign w_adv2     = !r_out_v || !i_out_stall;
    assign w_adv1     = !r_s1_v || w_adv2;
    assign w_adv0     = !r_s0_v || w_adv1;
    assign w_step     = r_s0_v && w_adv1;
    assign o_in_stall = !w_adv0;

    assign w_th_inc  = {1'b0, i_cfg_wdata[TH_W-1:0]} + (TH_W+1)'(1);
    assign w_lim_new = SUM_W'(w_th_inc) * SUM_W'(WINDOW_LEN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq <= FREQ_RST;
            r_cur  <= CUR_RST;
            r_lim  <= LIM_RST;
            r_maxt <= MAXT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FREQ: begin
                    if (i_cfg_wdata >= CFG_W'(FREQ_MIN) && i_cfg_wdata <= CFG_W'(FREQ_MAX)) begin
                        r_freq <= i_cfg_wdata[FREQ_W-1:0];
                    end
                end
                CFG_CURRENT: begin
                    if (i_cfg_wdata >= CFG_W'(CUR_MIN) && i_cfg_wdata <= CFG_W'(CUR_MAX)) begin
                        r_cur <= i_cfg_wdata[CUR_W-1:0];
                    end
                end
                CFG_SLOPE: begin
                    if (i_cfg_wdata[CFG_W-1:TH_W] == '0) begin
                        r_lim <= w_lim_new;
                    end
                end
                CFG_MAXT: begin
                    if (i_cfg_wdata != '0) begin
                        r_maxt <= i_cfg_wdata[MAXT_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (w_adv0) begin
            r_s0_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv0 && i_in_valid) begin
            r_s0_func  <= t_func'(i_func);
            r_s0_rr    <= i_rr_ms;
            r_s0_now   <= i_now_ms;
            r_s0_grant <= i_grant;
        end
    end

    assign w_old      = r_win[r_wpos];
    assign w_diff     = (r_last_rr != '0)
                      ? (signed'({1'b0, r_s0_rr}) - signed'({1'b0, r_last_rr}))
                      : '0;
    assign w_sum_beat = r_sum - SUM_W'(w_old) + SUM_W'(w_diff);
    assign w_sum_x    = (SUM_W+1)'(w_sum_beat);
    assign w_lim_x    = signed'({1'b0, r_lim});
    assign w_above    = w_sum_x >= w_lim_x;
    assign w_below    = w_sum_x <= -w_lim_x;
    assign w_elapsed  = r_s0_now - r_start;
    assign w_timeout  = w_elapsed >= TIME_W'(r_maxt);

    always_comb begin
        n_wpos    = r_wpos;
        n_sum     = r_sum;
        n_last_rr = r_last_rr;
        n_phase   = r_phase;
        n_start   = r_start;
        n_cnt     = r_cnt;
        n_dur     = r_dur;
        n_ok      = r_ok;
        n_en      = 1'b0;
        n_dis     = 1'b0;
        unique case (r_s0_func)
            FN_BEAT: begin
                n_wpos    = (r_wpos == POS_LAST) ? '0 : r_wpos + PW'(1);
                n_sum     = w_sum_beat;
                n_last_rr = r_s0_rr;
                if (r_phase == PH_STIM) begin
                    if (w_above) begin
                        n_dur   = w_elapsed;
                        n_phase = PH_COOL;
                        n_dis   = 1'b1;
                    end
                end else if (w_below) begin
                    n_phase = PH_STIM;
                    n_start = r_s0_now;
                    n_ok    = 1'b0;
                    n_cnt   = r_cnt + CNT_W'(1);
                    n_en    = 1'b1;
                end
            end
            FN_TICK: begin
                if (r_phase == PH_STIM && w_timeout) begin
                    n_phase = PH_IDLE;
                    n_ok    = 1'b0;
                    n_dis   = 1'b1;
                end
            end
            FN_FORCE_OFF: begin
                n_dis   = (r_phase == PH_STIM);
                n_phase = PH_IDLE;
                n_ok    = 1'b0;
            end
            FN_SAFETY: begin
                if (r_s0_grant) begin
                    n_ok = 1'b1;
                end else begin
                    n_dis   = (r_phase == PH_STIM);
                    n_phase = PH_IDLE;
                    n_ok    = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
                r_win[i] <= '0;
            end
            r_wpos    <= '0;
            r_sum     <= '0;
            r_last_rr <= '0;
            r_phase   <= PH_IDLE;
            r_start   <= '0;
            r_cnt     <= '0;
            r_dur     <= '0;
            r_ok      <= 1'b0;
            r_s1_v    <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_s1_v <= r_s0_v;
            end
            if (w_step) begin
                if (r_s0_func == FN_BEAT) begin
                    r_win[r_wpos] <= w_diff;
                end
                r_wpos    <= n_wpos;
                r_sum     <= n_sum;
                r_last_rr <= n_last_rr;
                r_phase   <= n_phase;
                r_start   <= n_start;
                r_cnt     <= n_cnt;
                r_dur     <= n_dur;
                r_ok      <= n_ok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_s1_phase <= n_phase;
            r_s1_en    <= n_en;
            r_s1_dis   <= n_dis;
            r_s1_freq  <= r_freq;
            r_s1_cur   <= r_cur;
            r_s1_cnt   <= n_cnt;
            r_s1_dur   <= n_dur;
            r_s1_ok    <= n_ok;
            r_s1_sum   <= n_sum;
        end
    end

    rpsg_mean #(
        .WINDOW_LEN (WINDOW_LEN),
        .SUM_W      (SUM_W)
    ) u_mean (
        .i_sum  (r_s1_sum),
        .o_mean (w_mean)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_adv2) begin
            r_out_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv2 && r_s1_v) begin
            r_out_phase <= r_s1_phase;
            r_out_en    <= r_s1_en;
            r_out_dis   <= r_s1_dis;
            r_out_freq  <= r_s1_freq;
            r_out_cur   <= r_s1_cur;
            r_out_cnt   <= r_s1_cnt;
            r_out_dur   <= r_s1_dur;
            r_out_ok    <= r_s1_ok;
            r_out_mean  <= w_mean;
        end
    end

    assign o_out_valid        = r_out_v;
    assign o_phase            = 2'(r_out_phase);
    assign o_gate_on          = (r_out_phase == PH_STIM);
    assign o_enable_event     = r_out_en;
    assign o_disable_event    = r_out_dis;
    assign o_cmd_freq_hz      = r_out_freq;
    assign o_cmd_current_ua   = r_out_cur;
    assign o_stim_total       = r_out_cnt;
    assign o_last_duration_ms = r_out_dur;
    assign o_safety_ok        = r_out_ok;
    assign o_slope_avg        = r_out_mean;

endmodule

### hw/rtl/rpsg_checker.sv
// Port-level checker of the phase stimulation gate, bound to its top level.
// Uses rpsg_pkg and the assertion macros of rsa_phase_stim_gate_defines.svh.
`include "rsa_phase_stim_gate_defines.svh"

module rpsg_checker
    import rpsg_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_in_stall,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic [1:0]               o_phase,
    input logic                     o_gate_on,
    input logic                     o_enable_event,
    input logic                     o_disable_event,
    input logic [FREQ_W-1:0]        o_cmd_freq_hz,
    input logic [CUR_W-1:0]         o_cmd_current_ua,
    input logic [CNT_W-1:0]         o_stim_total,
    input logic signed [MEAN_W-1:0] o_slope_avg
);

    `RPSG_ASSERT_NOW(a_empty_no_stall, i_clk, i_rst_n, !o_out_valid, !o_in_stall, "request stalled with empty output")
    `RPSG_ASSERT_NOW(a_event_gate, i_clk, i_rst_n, o_out_valid, (!o_enable_event || o_gate_on) && (!o_disable_event || !o_gate_on), "event disagrees with gate")
    `RPSG_ASSERT_NOW(a_cmd_range, i_clk, i_rst_n, o_out_valid, o_cmd_freq_hz >= FREQ_MIN && o_cmd_freq_hz <= FREQ_MAX && o_cmd_current_ua >= CUR_MIN && o_cmd_current_ua <= CUR_MAX, "command outside register range")
    `RPSG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_phase) && $stable(o_stim_total) && $stable(o_slope_avg), "stalled result changed")

endmodule

bind rsa_phase_stim_gate rpsg_checker u_rpsg_checker (.*);

### verif/rsa_phase_stim_gate_tb.sv
// Self-checking testbench of the phase stimulation gate: RR beats, ticks, forced offs and
// safety responses are checked against an in-bench predictor of the gate.
// Depends on rpsg_pkg and rsa_phase_stim_gate.
module rsa_phase_stim_gate_tb
    import rpsg_pkg::*;
();

    localparam int WIN_LEN     = 8;
    localparam int SLOPE_MAX   = 4095;
    localparam int MAXT_MIN    = 1;
    localparam int MAXT_MAX    = 65535;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 4;

    typedef enum logic [1:0] {
        PHASE_IDLE = 2'd0,
        PHASE_STIM = 2'd1,
        PHASE_COOL = 2'd2
    } t_gate_phase;

    typedef struct {
        t_func              func;
        logic [RR_W-1:0]    rr;
        logic [TIME_W-1:0]  now;
        logic               grant;
    } t_gate_req;

    typedef struct {
        logic [1:0]               phase;
        logic                     gate_on;
        logic                     en_ev;
        logic                     dis_ev;
        logic [FREQ_W-1:0]        freq;
        logic [CUR_W-1:0]         cur;
        logic [CNT_W-1:0]         total;
        logic [TIME_W-1:0]        dur;
        logic                     ok;
        logic signed [MEAN_W-1:0] mean;
    } t_gate_status;

    logic                     i_clk;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [FUNC_W-1:0]        i_func = '0;
    logic [RR_W-1:0]          i_rr_ms = '0;
    logic [TIME_W-1:0]        i_now_ms = '0;
    logic                     i_grant = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic [1:0]               o_phase;
    logic                     o_gate_on;
    logic                     o_enable_event;
    logic                     o_disable_event;
    logic [FREQ_W-1:0]        o_cmd_freq_hz;
    logic [CUR_W-1:0]         o_cmd_current_ua;
    logic [CNT_W-1:0]         o_stim_total;
    logic [TIME_W-1:0]        o_last_duration_ms;
    logic                     o_safety_ok;
    logic signed [MEAN_W-1:0] o_slope_avg;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_idx = '0;
    logic [CFG_W-1:0]         i_cfg_wdata = '0;

    rsa_phase_stim_gate #(.WINDOW_LEN(WIN_LEN)) dut (.*);

    // predictor state
    logic [FREQ_W-1:0] cfg_freq  = FREQ_RST;
    logic [CUR_W-1:0]  cfg_cur   = CUR_RST;
    int                slope_th  = TH_RST;
    logic [MAXT_W-1:0] max_ms    = MAXT_RST;
    int                rr_diffs[WIN_LEN] = '{default: 0};
    int                wr_idx    = 0;
    int                diff_total = 0;
    logic [RR_W-1:0]   prev_rr   = '0;
    t_gate_phase       gate_phase = PHASE_IDLE;
    logic [TIME_W-1:0] stim_start = '0;
    logic [CNT_W-1:0]  start_tally = '0;
    logic [TIME_W-1:0] stim_len   = '0;
    logic              granted    = 1'b0;

    t_gate_req    reqs_waiting[$];
    t_gate_status status_due[$];
    t_gate_req    on_bus;
    int           mismatches = 0;
    int           send_idle_pct = 31;
    int           recv_idle_pct = 75;
    logic         hold_arm = 1'b0;
    logic         hold_done = 1'b0;
    int           hold_left = 0;

    // traffic shaping state
    logic [TIME_W-1:0] clock_ms = '0;
    int                rr_cur = 800;
    int                trend = -1;
    int                run_left = 0;
    int                stride = 10;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic logic drop_to_idle();
        logic was_open;
        was_open = (gate_phase == PHASE_STIM);
        gate_phase = PHASE_IDLE;
        granted = 1'b0;
        return was_open;
    endfunction

    function automatic t_gate_status advance_gate(t_gate_req r);
        t_gate_status res;
        int d;
        int mean_v;
        logic [TIME_W-1:0] elapsed;
        res.en_ev = 1'b0;
        res.dis_ev = 1'b0;
        case (r.func)
            FN_BEAT: begin
                d = (prev_rr != 0) ? int'(r.rr) - int'(prev_rr) : 0;
                diff_total = diff_total - rr_diffs[wr_idx] + d;
                rr_diffs[wr_idx] = d;
                wr_idx = (wr_idx + 1) % WIN_LEN;
                prev_rr = r.rr;
                mean_v = diff_total / WIN_LEN;
                if (gate_phase == PHASE_STIM) begin
                    if (mean_v > slope_th) begin
                        stim_len = r.now - stim_start;
                        gate_phase = PHASE_COOL;
                        res.dis_ev = 1'b1;
                    end
                end else if (mean_v < -slope_th) begin
                    gate_phase = PHASE_STIM;
                    stim_start = r.now;
                    granted = 1'b0;
                    start_tally = start_tally + 1'b1;
                    res.en_ev = 1'b1;
                end
            end
            FN_TICK: begin
                elapsed = r.now - stim_start;
                if (gate_phase == PHASE_STIM && elapsed >= TIME_W'(max_ms))
                    res.dis_ev = drop_to_idle();
            end
            FN_FORCE_OFF: res.dis_ev = drop_to_idle();
            default: begin
                if (!r.grant)
                    res.dis_ev = drop_to_idle();
                else
                    granted = 1'b1;
            end
        endcase
        mean_v = diff_total / WIN_LEN;
        res.phase = gate_phase;
        res.gate_on = (gate_phase == PHASE_STIM);
        res.freq = cfg_freq;
        res.cur = cfg_cur;
        res.total = start_tally;
        res.dur = stim_len;
        res.ok = granted;
        res.mean = MEAN_W'(mean_v);
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, longint got, longint want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid)
                status_due.push_back(advance_gate(on_bus));
            if (reqs_waiting.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                on_bus = reqs_waiting.pop_front();
                i_in_valid <= 1'b1;
                i_func <= on_bus.func;
                i_rr_ms <= on_bus.rr;
                i_now_ms <= on_bus.now;
                i_grant <= on_bus.grant;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with one long hold-off when armed
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_arm && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_gate_status want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (status_due.size() == 0) begin
                report_mismatch("status with no request outstanding");
            end else begin
                want = status_due.pop_front();
                check_field("phase", o_phase, want.phase);
                check_field("gate_on", o_gate_on, want.gate_on);
                check_field("enable_event", o_enable_event, want.en_ev);
                check_field("disable_event", o_disable_event, want.dis_ev);
                check_field("cmd_freq_hz", o_cmd_freq_hz, want.freq);
                check_field("cmd_current_ua", o_cmd_current_ua, want.cur);
                check_field("stim_total", o_stim_total, want.total);
                check_field("last_duration_ms", o_last_duration_ms, want.dur);
                check_field("safety_ok", o_safety_ok, want.ok);
                check_field("slope_avg", o_slope_avg, want.mean);
            end
        end
    end

    task automatic push_req(t_func func, int rr, logic [TIME_W-1:0] now, logic grant);
        t_gate_req r;
        r.func = func;
        r.rr = RR_W'(rr);
        r.now = now;
        r.grant = grant;
        reqs_waiting.push_back(r);
    endtask

    task automatic write_reg(t_cfg_idx idx, int val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= CFG_W'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_FREQ:    if (val >= FREQ_MIN && val <= FREQ_MAX) cfg_freq = FREQ_W'(val);
            CFG_CURRENT: if (val >= CUR_MIN && val <= CUR_MAX) cfg_cur = CUR_W'(val);
            CFG_SLOPE:   if (val <= SLOPE_MAX) slope_th = val;
            default:     if (val >= MAXT_MIN && val <= MAXT_MAX) max_ms = MAXT_W'(val);
        endcase
    endtask

    task automatic drain();
        while (reqs_waiting.size() != 0 || i_in_valid || status_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // breathing-like RR trends with ticks, safety and forced-off traffic, plus some noise
    task automatic gen_traffic(int count);
        t_gate_req r;
        int pick;
        int jitter;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            clock_ms = clock_ms + $urandom_range(0, 700);
            r.rr = RR_W'($urandom);
            r.now = clock_ms;
            r.grant = 1'($urandom_range(1));
            if (pick < 60) begin
                if (run_left == 0) begin
                    trend = -trend;
                    run_left = $urandom_range(6, 16);
                    stride = $urandom_range(2, 80);
                end
                run_left--;
                jitter = $urandom_range(10);
                rr_cur = rr_cur + trend * stride + jitter - 5;
                if (rr_cur < 1) rr_cur = 1;
                if (rr_cur > 4095) rr_cur = 4095;
                r.func = FN_BEAT;
                r.rr = RR_W'(rr_cur);
            end else if (pick < 72) begin
                r.func = FN_TICK;
            end else if (pick < 82) begin
                r.func = FN_SAFETY;
                r.grant = ($urandom_range(99) < 80);
            end else if (pick < 87) begin
                r.func = FN_FORCE_OFF;
            end else begin
                r.func = t_func'($urandom_range(3));
                r.now = $urandom;
            end
            reqs_waiting.push_back(r);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_req(FN_TICK, 0, 32'd0, 1'b0);
        push_req(FN_FORCE_OFF, 0, 32'd10, 1'b0);
        push_req(FN_SAFETY, 0, 32'd20, 1'b0);
        push_req(FN_SAFETY, 0, 32'd30, 1'b1);
        push_req(FN_BEAT, 0, 32'd40, 1'b0);
        push_req(FN_BEAT, 4095, 32'd50, 1'b0);
        push_req(FN_BEAT, 1, 32'd1000, 1'b0);
        push_req(FN_SAFETY, 0, 32'd1100, 1'b1);
        push_req(FN_TICK, 0, 32'd5999, 1'b0);
        push_req(FN_TICK, 0, 32'd6000, 1'b0);
        push_req(FN_BEAT, 4095, 32'd7000, 1'b0);
        push_req(FN_BEAT, 3000, 32'hFFFF_FFF0, 1'b0);
        push_req(FN_TICK, 0, 32'h0000_1377, 1'b0);
        push_req(FN_BEAT, 4000, 32'h100, 1'b0);
        push_req(FN_BEAT, 4095, 32'h200, 1'b0);
        push_req(FN_BEAT, 4095, 32'h240, 1'b0);
        push_req(FN_BEAT, 4095, 32'h280, 1'b0);
        push_req(FN_BEAT, 4095, 32'h2C0, 1'b0);
        push_req(FN_BEAT, 4095, 32'h300, 1'b0);
        push_req(FN_BEAT, 3000, 32'h400, 1'b0);
        push_req(FN_SAFETY, 0, 32'h500, 1'b1);
        push_req(FN_FORCE_OFF, 0, 32'h600, 1'b0);
        push_req(FN_BEAT, 2000, 32'h700, 1'b0);
        push_req(FN_SAFETY, 0, 32'h800, 1'b0);
        drain();

        // range extremes, then rejected writes
        write_reg(CFG_FREQ, 1000);
        write_reg(CFG_CURRENT, 5000);
        write_reg(CFG_SLOPE, 0);
        write_reg(CFG_MAXT, 1);
        write_reg(CFG_FREQ, 0);
        write_reg(CFG_FREQ, 1001);
        write_reg(CFG_CURRENT, 99);
        write_reg(CFG_CURRENT, 5001);
        write_reg(CFG_SLOPE, 4096);
        write_reg(CFG_MAXT, 0);
        clock_ms = 32'hFFFF_0000;
        gen_traffic(260);
        drain();

        write_reg(CFG_FREQ, 1);
        write_reg(CFG_CURRENT, 100);
        write_reg(CFG_SLOPE, 4095);
        write_reg(CFG_MAXT, 65535);
        gen_traffic(150);
        drain();

        send_idle_pct <= 75;
        recv_idle_pct <= 31;
        write_reg(CFG_FREQ, 500);
        write_reg(CFG_CURRENT, 2500);
        write_reg(CFG_SLOPE, 20);
        write_reg(CFG_MAXT, 300);
        gen_traffic(320);
        drain();

        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        write_reg(CFG_FREQ, 37);
        write_reg(CFG_SLOPE, 3);
        write_reg(CFG_MAXT, 2000);
        hold_arm <= 1'b1;
        gen_traffic(300);
        drain();

        if (status_due.size() != 0)
            report_mismatch($sformatf("%0d statuses never arrived", status_due.size()));
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
